@@ sv/phcm_pkg.sv @@
package phcm_pkg;

    // Opcodes carried in s_axis_tuser
    localparam logic OP_UPDATE = 1'b0;
    localparam logic OP_STATS  = 1'b1;

    // Configuration register indexes
    localparam logic [1:0] CFG_NUM_BUFFERS     = 2'd0;
    localparam logic [1:0] CFG_MAX_COUNT       = 2'd1;
    localparam logic [1:0] CFG_COUNT_THRESHOLD = 2'd2;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 9;

    // Stream payload widths, padded to whole bytes
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 40;

    localparam int QUOT_W = 7;
    localparam logic [QUOT_W-1:0] PERCENT_SCALE = 7'd100;

    // Classified command handed from the front end to the execution side
    typedef struct packed {
        logic       op;
        logic       err;
        logic [5:0] src_index;
        logic [5:0] dst_index;
        logic [7:0] amount;
    } t_cmd;

    typedef struct packed {
        logic [6:0]  percent_over;
        logic [12:0] pairs_total;
        logic [12:0] pairs_over;
        logic        status;
    } t_result;

endpackage

@@ sv/phcm_front.sv @@
module phcm_front (
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_op,
    input  logic [phcm_pkg::IN_DATA_W-1:0] i_data,
    input  logic [6:0]                    i_side,
    input  logic                          i_hold,
    input  logic                          i_queue_full,
    output logic                          o_push,
    output phcm_pkg::t_cmd                o_cmd
);
    import phcm_pkg::*;

    logic [5:0] src;
    logic [5:0] dst;

    assign src = i_data[5:0];
    assign dst = i_data[11:6];

    // Take a transaction only when the queue has room and the store is usable
    assign o_ready = !i_queue_full && !i_hold;
    assign o_push  = i_valid && o_ready;

    always_comb begin
        o_cmd.op        = i_op;
        o_cmd.src_index = src;
        o_cmd.dst_index = dst;
        o_cmd.amount    = i_data[19:12];
        // flag updates that fall outside the matrix in use
        o_cmd.err       = (i_op == OP_UPDATE) &&
                          ((7'(src) >= i_side) || (7'(dst) >= i_side));
    end

endmodule

@@ sv/phcm_fifo.sv @@
module phcm_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  phcm_pkg::t_cmd i_cmd,
    output logic           o_full,
    output logic           o_valid,
    output phcm_pkg::t_cmd o_cmd,
    input  logic           i_pop
);
    import phcm_pkg::*;

    t_cmd       r_buf [2];
    logic       r_wp, n_wp;
    logic       r_rp, n_rp;
    logic [1:0] r_cnt, n_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd   = r_buf[r_rp];

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wp = !r_wp;
        end
        if (i_pop) begin
            n_rp = !r_rp;
        end
        case ({i_push, i_pop})
            2'b10:   n_cnt = r_cnt + 2'd1;
            2'b01:   n_cnt = r_cnt - 2'd1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

endmodule

@@ sv/phcm_div.sv @@
module phcm_div #(
    parameter int TOT_W = 13
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [TOT_W-1:0]              i_over,
    input  logic [TOT_W-1:0]              i_total,
    output logic                          o_done,
    output logic [phcm_pkg::QUOT_W-1:0]   o_quot
);
    import phcm_pkg::*;

    localparam int DIV_W = TOT_W + QUOT_W;

    logic [DIV_W-1:0]  r_rem, n_rem;
    logic [DIV_W-1:0]  r_div, n_div;
    logic [QUOT_W-1:0] r_q, n_q;
    logic [2:0]        r_cnt, n_cnt;
    logic              r_run, n_run;
    logic              r_done, n_done;
    logic              r_zero, n_zero;

    assign o_done = r_done;
    assign o_quot = r_zero ? '0 : r_q;

    // Restoring division, one quotient bit per cycle; quotient never exceeds 100
    always_comb begin
        n_rem  = r_rem;
        n_div  = r_div;
        n_q    = r_q;
        n_cnt  = r_cnt;
        n_run  = r_run;
        n_zero = r_zero;
        n_done = 1'b0;
        if (i_start) begin
            n_rem  = DIV_W'(i_over) * DIV_W'(PERCENT_SCALE);
            n_div  = DIV_W'(i_total) << (QUOT_W - 1);
            n_q    = '0;
            n_cnt  = 3'(QUOT_W);
            n_run  = 1'b1;
            n_zero = (i_total == '0);
        end else if (r_run) begin
            if (r_rem >= r_div) begin
                n_rem = r_rem - r_div;
                n_q   = {r_q[QUOT_W-2:0], 1'b1};
            end else begin
                n_q   = {r_q[QUOT_W-2:0], 1'b0};
            end
            n_div = r_div >> 1;
            n_cnt = r_cnt - 3'd1;
            if (r_cnt == 3'd1) begin
                n_run  = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_div  <= n_div;
        r_q    <= n_q;
        r_cnt  <= n_cnt;
        r_zero <= n_zero;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_run  <= n_run;
            r_done <= n_done;
        end
    end

endmodule

@@ sv/phcm_back.sv @@
module phcm_back #(
    parameter int MAX_BUFFERS = 64,
    parameter int COUNT_BITS  = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [6:0]        i_side,
    input  logic [7:0]        i_max_count,
    input  logic [8:0]        i_count_threshold,
    input  logic              i_cmd_valid,
    input  phcm_pkg::t_cmd    i_cmd,
    output logic              o_cmd_pop,
    output logic              o_clearing,
    output logic              o_res_valid,
    output phcm_pkg::t_result o_res,
    input  logic              i_res_ready
);
    import phcm_pkg::*;

    localparam int DEPTH  = MAX_BUFFERS * MAX_BUFFERS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int TOT_W  = ADDR_W + 1;
    localparam int SUM_W  = ((COUNT_BITS > 8) ? COUNT_BITS : 8) + 1;
    localparam int CMP_W  = (COUNT_BITS > 9) ? COUNT_BITS : 9;
    localparam logic [SUM_W-1:0] CELL_MAX  = SUM_W'((64'd1 << COUNT_BITS) - 64'd1);
    localparam logic [TOT_W-1:0] LAST_ADDR = TOT_W'(DEPTH - 1);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_UPD   = 3'd2;
    localparam logic [2:0] ST_SCAN  = 3'd3;
    localparam logic [2:0] ST_DIV   = 3'd4;

    logic [COUNT_BITS-1:0] r_mem [DEPTH];
    logic [COUNT_BITS-1:0] r_rd_data;

    logic [2:0]        r_state, n_state;
    logic [TOT_W-1:0]  r_ptr, n_ptr;
    logic [TOT_W-1:0]  r_total, n_total;
    logic [TOT_W-1:0]  r_over, n_over;
    logic              r_rd_vld, n_rd_vld;
    logic [ADDR_W-1:0] r_upd_addr, n_upd_addr;
    logic [7:0]        r_amount, n_amount;
    logic              r_out_valid, n_out_valid;
    t_result           r_out, n_out;

    logic [13:0]           idx_sum;
    logic [ADDR_W-1:0]     cell_addr;
    logic [TOT_W-1:0]      total_calc;
    logic [SUM_W-1:0]      sum;
    logic [SUM_W-1:0]      limit;
    logic                  hit;
    logic                  out_free;
    logic                  mem_we;
    logic [ADDR_W-1:0]     mem_waddr;
    logic [COUNT_BITS-1:0] mem_wdata;
    logic [ADDR_W-1:0]     mem_raddr;
    logic                  div_start;
    logic                  div_done;
    logic [QUOT_W-1:0]     div_quot;

    assign idx_sum    = 14'(i_cmd.src_index) * 14'(i_side) + 14'(i_cmd.dst_index);
    assign cell_addr  = ADDR_W'(idx_sum);
    assign total_calc = TOT_W'(14'(i_side) * 14'(i_side));
    assign sum        = SUM_W'(r_rd_data) + SUM_W'(r_amount);
    assign limit      = (SUM_W'(i_max_count) > CELL_MAX) ? CELL_MAX : SUM_W'(i_max_count);
    assign hit        = CMP_W'(r_rd_data) >= CMP_W'(i_count_threshold);
    assign out_free   = !r_out_valid || i_res_ready;

    assign o_clearing  = (r_state == ST_CLEAR);
    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

    assign mem_raddr = (r_state == ST_IDLE) ? cell_addr : r_ptr[ADDR_W-1:0];

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_upd_addr;
        mem_wdata = COUNT_BITS'(sum);
        if (r_state == ST_CLEAR) begin
            mem_we    = 1'b1;
            mem_waddr = r_ptr[ADDR_W-1:0];
            mem_wdata = '0;
        end else if (r_state == ST_UPD) begin
            mem_we = (sum <= limit);
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= r_mem[mem_raddr];
    end

    phcm_div #(
        .TOT_W (TOT_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_over  (r_over),
        .i_total (r_total),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    always_comb begin
        n_state     = r_state;
        n_ptr       = r_ptr;
        n_total     = r_total;
        n_over      = r_over;
        n_rd_vld    = 1'b0;
        n_upd_addr  = r_upd_addr;
        n_amount    = r_amount;
        n_out_valid = r_out_valid && !i_res_ready;
        n_out       = r_out;
        o_cmd_pop   = 1'b0;
        div_start   = 1'b0;

        if (r_rd_vld && hit) begin
            n_over = r_over + TOT_W'(1);
        end

        case (r_state)
            ST_CLEAR: begin
                if (r_ptr == LAST_ADDR) begin
                    n_ptr   = '0;
                    n_state = ST_IDLE;
                end else begin
                    n_ptr = r_ptr + TOT_W'(1);
                end
            end
            ST_IDLE: begin
                if (i_cmd_valid && out_free) begin
                    o_cmd_pop = 1'b1;
                    if (i_cmd.op == OP_STATS) begin
                        n_ptr   = '0;
                        n_over  = '0;
                        n_total = total_calc;
                        n_state = ST_SCAN;
                    end else if (i_cmd.err) begin
                        n_out_valid = 1'b1;
                        n_out       = '0;
                        n_out.status = 1'b1;
                    end else begin
                        n_upd_addr = cell_addr;
                        n_amount   = i_cmd.amount;
                        n_state    = ST_UPD;
                    end
                end
            end
            ST_UPD: begin
                n_out_valid = 1'b1;
                n_out       = '0;
                n_state     = ST_IDLE;
            end
            ST_SCAN: begin
                if (r_ptr != r_total) begin
                    n_ptr    = r_ptr + TOT_W'(1);
                    n_rd_vld = 1'b1;
                end else if (!r_rd_vld) begin
                    div_start = 1'b1;
                    n_state   = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    n_out_valid        = 1'b1;
                    n_out.status       = 1'b0;
                    n_out.pairs_over   = 13'(r_over);
                    n_out.pairs_total  = 13'(r_total);
                    n_out.percent_over = div_quot;
                    n_state            = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_total    <= n_total;
        r_over     <= n_over;
        r_upd_addr <= n_upd_addr;
        r_amount   <= n_amount;
        r_out      <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_ptr       <= '0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ptr       <= n_ptr;
            r_rd_vld    <= n_rd_vld;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

@@ sv/pair_hit_count_matrix.sv @@
// Square matrix of hit counters, one COUNT_BITS cell per (source, destination)
// buffer pair, held in a single-port-write, registered-read RAM of
// MAX_BUFFERS*MAX_BUFFERS cells. After reset the block sweeps the RAM to zero,
// one cell per cycle; s_axis_tready stays low for that sweep while
// configuration writes are taken as usual. A front end checks indices against
// the side in use and hands each transaction through a two-entry queue to the
// execution side, so input keeps flowing, until the queue fills, while a
// result waits in the output register. An update does a RAM read, then add,
// limit compare and write-back; a sum above the maximum leaves the cell as it
// was. An out-of-range update answers with status 1 and writes nothing to the
// RAM. A statistics transaction walks every cell in use, one RAM read per
// cycle, then runs a shift-subtract divider for the percentage. Change
// configuration only while no transaction is in flight.
module pair_hit_count_matrix #(
    parameter int MAX_BUFFERS = 64,
    parameter int COUNT_BITS  = 8
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // configuration write port
    input  logic                                 i_cfg_we,
    input  logic [phcm_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  logic [phcm_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    // input stream
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // [5:0] src_index, [11:6] dst_index, [19:12] amount, [23:20] zero
    input  logic [phcm_pkg::IN_DATA_W-1:0]       s_axis_tdata,
    // [0] op
    input  logic                                 s_axis_tuser,
    // result stream
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // [0] status, [13:1] pairs_over, [26:14] pairs_total,
    // [33:27] percent_over, [39:34] zero
    output logic [phcm_pkg::OUT_DATA_W-1:0]      m_axis_tdata
);
    import phcm_pkg::*;

    logic [6:0] r_num_buffers;
    logic [7:0] r_max_count;
    logic [8:0] r_count_threshold;

    logic       side_over;
    logic [6:0] side;
    logic       hold;
    logic       q_full;
    logic       q_push;
    t_cmd       q_in;
    logic       q_valid;
    t_cmd       q_out;
    logic       q_pop;
    logic       res_valid;
    t_result    res;

    // Configuration registers: write-only, taken on any cycle the enable is high
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_buffers     <= 7'd64;
            r_max_count       <= 8'd255;
            r_count_threshold <= 9'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_NUM_BUFFERS:     r_num_buffers     <= i_cfg_data[6:0];
                CFG_MAX_COUNT:       r_max_count       <= i_cfg_data[7:0];
                CFG_COUNT_THRESHOLD: r_count_threshold <= i_cfg_data;
                default: begin
                    // unused index: drop the write
                end
            endcase
        end
    end

    // Clamp the side to what the store can hold
    assign side_over = (32'(r_num_buffers) > 32'(MAX_BUFFERS));
    assign side      = side_over ? 7'(MAX_BUFFERS) : r_num_buffers;

    phcm_front u_front (
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_op         (s_axis_tuser),
        .i_data       (s_axis_tdata),
        .i_side       (side),
        .i_hold       (hold),
        .i_queue_full (q_full),
        .o_push       (q_push),
        .o_cmd        (q_in)
    );

    phcm_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (q_out),
        .i_pop   (q_pop)
    );

    phcm_back #(
        .MAX_BUFFERS (MAX_BUFFERS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_side            (side),
        .i_max_count       (r_max_count),
        .i_count_threshold (r_count_threshold),
        .i_cmd_valid       (q_valid),
        .i_cmd             (q_out),
        .o_cmd_pop         (q_pop),
        .o_clearing        (hold),
        .o_res_valid       (res_valid),
        .o_res             (res),
        .i_res_ready       (m_axis_tready)
    );

    // Pack the result transaction, lowest field first
    assign m_axis_tvalid = res_valid;
    assign m_axis_tdata  = {6'd0, res.percent_over, res.pairs_total,
                            res.pairs_over, res.status};

endmodule
